// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Each macro expects clk_i and rst_ni to exist in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same check on a plain condition.
`define ASSERT_NOW(lbl, cond, msg) \
  `ASSERT_CHK(lbl, (cond), msg)

`endif

// ===== rtl/core/aalwf_pkg.sv =====
package aalwf_pkg;

  localparam int AddrW         = 48;
  localparam int ReqW          = 3;
  localparam int CountOutW     = 4;
  localparam int DefMaxEntries = 8;

  typedef enum logic [ReqW-1:0] {
    REQ_ADD     = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_CLEAR   = 3'd2,
    REQ_CONNECT = 3'd3,
    REQ_POLL    = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic                 wake_flag;
    logic [CountOutW-1:0] entry_count;
    logic [AddrW-1:0]     wake_address;
    logic                 wake_now;
    status_e              status;
  } res_t;

endpackage

// ===== rtl/core/address_allow_list_wake_filter_unit.sv =====
// Address allow list with a one-shot wake flag.
// The slave stream carries one request word per handshake: tuser holds the
// request kind (add, remove, clear, connection attempt, poll, other) and tdata
// holds the 48-bit peer address. Every request word yields exactly one result
// word on the master stream with status, wake report, entry count and flag.
// A request is handled by a sequencer that walks the stored list through one
// registered-read table port and one address comparator, one entry per cycle.
// Add, remove and connection walk the list of N entries; a hit ends the walk
// of an add or connection early, while a remove walks on to the end because
// closing the gap continues the walk past the match. Clear, poll and other
// requests skip the walk. The result word enters the output register on the
// same edge at which the sequencer turns ready for the next request.
// Reset empties the list and clears the wake flag; the table needs no clearing
// pass since only entries below the count are ever used.
// When the receiver stalls, the result word holds in the output register and
// one more finished result may wait in the sequencer; further requests are
// then held off by s_axis_tready.
module address_allow_list_wake_filter_unit #(
  parameter int MaxEntries = aalwf_pkg::DefMaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: peer_address[47:0]
  input  logic [47:0] s_axis_tdata,
  // tuser: req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], wake_now[2], wake_address[50:3], entry_count[54:51],
  // wake_flag[55]
  output logic [55:0] m_axis_tdata
);
  import aalwf_pkg::*;

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [AddrW-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [AddrW-1:0] ram_rdata;
  res_t             out_q;
  logic             out_valid_q;

  aalwf_ram #(
    .Width (AddrW),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  aalwf_ctrl #(
    .MaxEntries (MaxEntries)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.wake_flag, out_q.entry_count, out_q.wake_address,
                          out_q.wake_now, out_q.status};

endmodule

// ===== rtl/core/aalwf_ram.sv =====
module aalwf_ram #(
  parameter int Width = 48,
  parameter int Depth = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/aalwf_ctrl.sv =====
module aalwf_ctrl #(
  parameter int MaxEntries = aalwf_pkg::DefMaxEntries,
  parameter int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [aalwf_pkg::ReqW-1:0]  in_req_i,
  input  logic [aalwf_pkg::AddrW-1:0] in_addr_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output aalwf_pkg::res_t             res_o,
  output logic                        ram_we_o,
  output logic [IdxW-1:0]             ram_waddr_o,
  output logic [aalwf_pkg::AddrW-1:0] ram_wdata_o,
  output logic [IdxW-1:0]             ram_raddr_o,
  input  logic [aalwf_pkg::AddrW-1:0] ram_rdata_i
);
  import aalwf_pkg::*;
  `include "assert_macros.svh"

  localparam int CntW = $clog2(MaxEntries + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EXEC,
    S_DONE
  } state_e;

  state_e           state_q;
  req_e             req_q;
  logic [AddrW-1:0] key_q;
  logic [IdxW-1:0]  idx_q;
  logic [CntW-1:0]  count_q;
  logic             pending_q;
  logic             found_q;
  status_e          status_q;
  logic             wake_now_q;
  logic [AddrW-1:0] wake_addr_q;

  logic [CntW-1:0]  idx_inc;
  logic             hit;
  logic             needs_scan;

  assign idx_inc    = CntW'(idx_q) + CntW'(1);
  assign hit        = (ram_rdata_i == key_q);
  assign needs_scan = ((in_req_i == REQ_ADD) || (in_req_i == REQ_REMOVE) ||
                       (in_req_i == REQ_CONNECT)) && (count_q != '0);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o              = '0;
    res_o.status       = status_q;
    res_o.wake_now     = wake_now_q;
    res_o.wake_address = wake_addr_q;
    res_o.entry_count  = CountOutW'(count_q);
    res_o.wake_flag    = pending_q;
  end

  // The read port runs one entry ahead of the entry being compared or moved.
  always_comb begin
    ram_raddr_o = '0;
    if (state_q != S_IDLE) begin
      ram_raddr_o = idx_q + IdxW'(1) + IdxW'(state_q == S_SHIFT);
    end
  end

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = ram_rdata_i;
    if (state_q == S_SHIFT) begin
      ram_we_o = (idx_inc < count_q);
    end else if (state_q == S_EXEC && req_q == REQ_ADD) begin
      ram_we_o    = !found_q && (count_q < CntW'(MaxEntries));
      ram_waddr_o = IdxW'(count_q);
      ram_wdata_o = key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_ADD;
      key_q       <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      pending_q   <= 1'b0;
      found_q     <= 1'b0;
      status_q    <= ST_OK;
      wake_now_q  <= 1'b0;
      wake_addr_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= req_e'(in_req_i);
            key_q   <= in_addr_i;
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= needs_scan ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          if (hit) begin
            found_q <= 1'b1;
            state_q <= (req_q == REQ_REMOVE) ? S_SHIFT : S_EXEC;
          end else if (idx_inc >= count_q) begin
            state_q <= S_EXEC;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_SHIFT: begin
          if (idx_inc < count_q) begin
            idx_q <= idx_q + IdxW'(1);
          end else begin
            count_q     <= count_q - CntW'(1);
            status_q    <= ST_OK;
            wake_now_q  <= 1'b0;
            wake_addr_q <= '0;
            state_q     <= S_DONE;
          end
        end
        S_EXEC: begin
          status_q    <= ST_REFUSED;
          wake_now_q  <= 1'b0;
          wake_addr_q <= '0;
          state_q     <= S_DONE;
          unique case (req_q)
            REQ_ADD: begin
              if (found_q) begin
                status_q <= ST_REFUSED;
              end else if (count_q >= CntW'(MaxEntries)) begin
                status_q <= ST_FULL;
              end else begin
                count_q  <= count_q + CntW'(1);
                status_q <= ST_OK;
              end
            end
            REQ_CLEAR: begin
              count_q  <= '0;
              status_q <= ST_OK;
            end
            REQ_CONNECT: begin
              if (found_q) begin
                pending_q   <= 1'b1;
                wake_now_q  <= 1'b1;
                wake_addr_q <= key_q;
                status_q    <= ST_OK;
              end
            end
            REQ_POLL: begin
              if (pending_q) begin
                pending_q <= 1'b0;
                status_q  <= ST_OK;
              end
            end
            default: begin
              status_q <= ST_REFUSED;
            end
          endcase
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NOW(a_count_in_range, count_q <= CntW'(MaxEntries), "entry count above capacity")
  `ASSERT_NOW(a_write_in_list, (!ram_we_o || (CntW'(ram_waddr_o) <= count_q)), "table write past list end")
  `ASSERT_CHK(a_wake_reports_ok, ((res_valid_o && res_o.wake_now) |-> (res_o.status == ST_OK && res_o.wake_flag)), "wake without ok status or set flag")
  `ASSERT_CHK(a_busy_after_accept, ((in_valid_i && in_ready_o) |=> !in_ready_o), "ready right after accept")

endmodule

// ===== tb/allow_list_result_checker.sv =====
`timescale 1ns / 1ps

module allow_list_result_checker #(
  parameter int MaxEntries = aalwf_pkg::DefMaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  output int          fail_count_o,
  output int          waiting_count_o
);
  import aalwf_pkg::*;

  logic [AddrW-1:0] allow_list [MaxEntries];
  int               list_len;
  logic             wake_pend;
  res_t             expected_results [$];

  function automatic res_t predict_result(logic [ReqW-1:0] kind, logic [AddrW-1:0] addr);
    res_t r;
    int   hit;
    r        = '0;
    r.status = ST_REFUSED;
    hit      = -1;
    for (int i = 0; i < list_len; i++) begin
      if (hit < 0 && allow_list[i] == addr) begin
        hit = i;
      end
    end
    case (kind)
      REQ_ADD: begin
        if (hit >= 0) begin
          r.status = ST_REFUSED;
        end else if (list_len >= MaxEntries) begin
          r.status = ST_FULL;
        end else begin
          allow_list[list_len] = addr;
          list_len++;
          r.status = ST_OK;
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i < list_len - 1; i++) begin
            allow_list[i] = allow_list[i+1];
          end
          list_len--;
          r.status = ST_OK;
        end
      end
      REQ_CLEAR: begin
        list_len = 0;
        r.status = ST_OK;
      end
      REQ_CONNECT: begin
        if (hit >= 0) begin
          wake_pend      = 1'b1;
          r.wake_now     = 1'b1;
          r.wake_address = addr;
          r.status       = ST_OK;
        end
      end
      REQ_POLL: begin
        if (wake_pend) begin
          wake_pend = 1'b0;
          r.status  = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = CountOutW'(list_len);
    r.wake_flag   = wake_pend;
    return r;
  endfunction

  task automatic check_field(string fname, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      list_len     = 0;
      wake_pend    = 1'b0;
      fail_count_o = 0;
      expected_results.delete();
      waiting_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(),
                                predict_result(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          $error("Result word 0x%0h arrived with no request outstanding", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", AddrW'(want.status), AddrW'(got.status));
          check_field("wake_now", AddrW'(want.wake_now), AddrW'(got.wake_now));
          check_field("wake_address", want.wake_address, got.wake_address);
          check_field("entry_count", AddrW'(want.entry_count), AddrW'(got.entry_count));
          check_field("wake_flag", AddrW'(want.wake_flag), AddrW'(got.wake_flag));
        end
      end
      waiting_count_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import aalwf_pkg::*;

  localparam int              MaxEntries  = DefMaxEntries;
  localparam int              PoolSize    = 12;
  localparam int              RandItems   = 450;
  localparam int              StallLimit  = 2000;
  localparam logic [ReqW-1:0] REQ_SPARE5  = 3'd5;
  localparam logic [ReqW-1:0] REQ_SPARE6  = 3'd6;
  localparam logic [ReqW-1:0] REQ_SPARE7  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_data = '0;
  logic [2:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [55:0] m_data;

  logic        idle_on = 1'b1;
  int          fail_count;
  int          waiting_count;
  int          idle_cycles = 0;
  logic [47:0] addr_pool [PoolSize];

  always #5 clk_i = ~clk_i;

  address_allow_list_wake_filter_unit #(
    .MaxEntries(MaxEntries)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  allow_list_result_checker #(
    .MaxEntries(MaxEntries)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_valid),
    .s_axis_tready  (s_ready),
    .s_axis_tdata   (s_data),
    .s_axis_tuser   (s_user),
    .m_axis_tvalid  (m_valid),
    .m_axis_tready  (m_ready),
    .m_axis_tdata   (m_data),
    .fail_count_o   (fail_count),
    .waiting_count_o(waiting_count)
  );

  always @(posedge clk_i) begin
    m_ready <= idle_on ? ($urandom_range(99) >= 14) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand_addr();
    return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
  endfunction

  task automatic send_req(input logic [2:0] kind, input logic [47:0] addr);
    while (idle_on && $urandom_range(99) < 14) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= addr;
    do begin
      @(posedge clk_i);
    end while (!(s_valid && s_ready));
  endtask

  // The sender holds off until every outstanding word has been answered.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (waiting_count != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int          pick;
    logic [2:0]  kind;
    logic [47:0] addr;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = 48'hAAAA_AAAA_AAAA;
    addr_pool[3] = 48'h5555_5555_5555;
    for (int i = 4; i < PoolSize; i++) begin
      addr_pool[i] = rand_addr();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(REQ_POLL, addr_pool[2]);
    send_req(REQ_CONNECT, addr_pool[0]);
    send_req(REQ_REMOVE, addr_pool[1]);
    send_req(REQ_ADD, addr_pool[0]);
    send_req(REQ_ADD, addr_pool[1]);
    send_req(REQ_ADD, addr_pool[0]);
    send_req(REQ_CONNECT, addr_pool[1]);
    send_req(REQ_CONNECT, addr_pool[1]);
    send_req(REQ_POLL, '0);
    send_req(REQ_POLL, '1);
    send_req(REQ_SPARE5, addr_pool[1]);
    send_req(REQ_SPARE6, addr_pool[0]);
    send_req(REQ_SPARE7, addr_pool[3]);
    for (int i = 2; i < 8; i++) begin
      send_req(REQ_ADD, addr_pool[i]);
    end
    send_req(REQ_ADD, addr_pool[8]);
    send_req(REQ_ADD, addr_pool[5]);
    send_req(REQ_REMOVE, addr_pool[0]);
    send_req(REQ_CONNECT, addr_pool[3]);
    send_req(REQ_CLEAR, addr_pool[4]);
    send_req(REQ_POLL, addr_pool[4]);
    drain_results();

    for (int n = 0; n < RandItems; n++) begin
      idle_on = !(n >= 150 && n < 300);
      if (n % 100 == 50) begin
        drain_results();
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        kind = REQ_ADD;
      end else if (pick < 45) begin
        kind = REQ_REMOVE;
      end else if (pick < 50) begin
        kind = REQ_CLEAR;
      end else if (pick < 75) begin
        kind = REQ_CONNECT;
      end else if (pick < 94) begin
        kind = REQ_POLL;
      end else begin
        kind = 3'($urandom_range(REQ_SPARE5, REQ_SPARE7));
      end
      addr = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(PoolSize - 1)] : rand_addr();
      send_req(kind, addr);
    end
    idle_on = 1'b1;

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
